### design/pidc_pkg.sv
// Shared types and constants for the conditional anti-windup PID controller.
`default_nettype none

package pidc_pkg;

  localparam int unsigned ErrW    = 16;
  localparam int unsigned DtW     = 16;
  localparam int unsigned GainW   = 32;
  localparam int unsigned IntW    = 32;
  localparam int unsigned IBoundW = 31;
  localparam int unsigned OBoundW = 15;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned QuotW   = 32;
  localparam int unsigned ProdW   = 64;
  localparam int unsigned DivCntW = 5;

  localparam logic [CfgIdxW-1:0] CFG_GAIN_P  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_I  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_D  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_IBOUND  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OBOUND  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_PD,
    S_DD,
    S_ID,
    S_PROV,
    S_INT,
    S_I2,
    S_SUM,
    S_FIN
  } state_e;

  typedef struct packed {
    logic             start;
    logic [ErrW-1:0]  mag;
    logic [DtW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

### design/pidc_div.sv
// Bit-serial restoring divider: (mag * 2^16) / divisor, one quotient bit per cycle.
`default_nettype none

module pidc_div (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire pidc_pkg::div_req_t req_i,
  output pidc_pkg::div_rsp_t    rsp_o
);
  import pidc_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [QuotW-1:0]   quo_q, quo_d;
  logic [DtW-1:0]     rem_q, rem_d;
  logic [DtW-1:0]     dvs_q, dvs_d;
  logic [DtW:0]       rem_sh;
  logic               take;

  always_comb begin
    rem_sh = {rem_q, quo_q[QuotW-1]};
    take   = (rem_sh >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = {req_i.mag, {(QuotW-ErrW){1'b0}}};
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[QuotW-2:0], take};
      rem_d = take ? DtW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DtW-1:0];
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |=> busy_q)
    else $error("divider did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> !done_q && rem_q < dvs_q)
    else $error("divider remainder out of range");

endmodule

`default_nettype wire

### design/pid_conditional_antiwindup.sv
// Top level of the fixed-point PID controller with conditional-integration anti-windup.
//
// Input stream (s_axis): one transfer carries an error sample (Q7.8) and a time
// step (Q0.16 s) in tdata, and a clear request in tuser. Every input transfer
// yields exactly one output transfer (m_axis) holding the clamped drive (Q7.8).
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 gain_p,
// 1 gain_i, 2 gain_d, 3 integral bound, 4 output bound); the user must write it only
// while idle, as the block itself does not enforce this.
// A sample with a nonzero time step goes through the bit-serial divider for the
// derivative, followed by five passes through the shared 32x32 multiplier.
// A zero time step skips the divider; a clear request produces drive 0.
// One sample is in work at a time; s_axis_tready is high only while the
// sequencer is idle, so a new sample is taken only once the last one is through.
// The result sits in an output register, so the next sample is taken while it
// waits; if the receiver stalls, the sequencer holds in its last step until the
// register frees up.
// Reset clears the integral and previous error, zeroes the gains, and sets both
// bounds to their maximum.
`default_nettype none

module pid_conditional_antiwindup (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [31:0]                   s_axis_tdata,  // error_sample, time_step
  input  wire logic                          s_axis_tuser,  // clear_state
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [15:0]                        m_axis_tdata,  // drive
  input  wire logic                          cfg_we_i,
  input  wire logic [pidc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [pidc_pkg::CfgW-1:0]     cfg_data_i
);
  import pidc_pkg::*;

  state_e state_q, state_d;

  logic signed [GainW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [IBoundW-1:0]      ibound_q;
  logic [OBoundW-1:0]      obound_q;

  logic signed [IntW-1:0]  integ_q;
  logic signed [ErrW-1:0]  last_q;

  logic signed [ErrW-1:0]  e_q;
  logic [DtW-1:0]          dt_q;
  logic                    clr_q;
  logic                    neg_q;
  logic signed [QuotW-1:0] deriv_q;
  logic signed [ProdW-1:0] prod_q, acc_q, sum_q;
  logic                    out_valid_q;
  logic [ErrW-1:0]         out_data_q;

  logic signed [ErrW-1:0]  in_err;
  logic [DtW-1:0]          in_dt;
  logic                    accept;
  logic signed [ErrW:0]    diff;
  logic [ErrW:0]           diff_abs;
  logic signed [GainW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] prod_d;
  logic signed [ProdW-1:0] lim, neg_lim, ishr, clamped;
  logic                    worsen;
  logic signed [IntW+1:0]  ni, ib_pos, ib_neg;
  logic signed [IntW-1:0]  ni_clamp;
  logic signed [QuotW-1:0] deriv_d;
  logic                    out_free;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  assign in_err   = s_axis_tdata[ErrW-1:0];
  assign in_dt    = s_axis_tdata[ErrW+DtW-1:ErrW];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign diff     = {in_err[ErrW-1], in_err} - {last_q[ErrW-1], last_q};
  assign diff_abs = diff[ErrW] ? (ErrW+1)'(-diff) : diff;

  assign div_req.start   = accept && !s_axis_tuser && (in_dt != '0);
  assign div_req.mag     = diff_abs[ErrW-1:0];
  assign div_req.divisor = in_dt;

  pidc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // signed quotient, saturated to 32 bits
  always_comb begin
    if (!neg_q) begin
      deriv_d = div_rsp.quot[QuotW-1] ? {1'b0, {(QuotW-1){1'b1}}} : div_rsp.quot;
    end else if (div_rsp.quot[QuotW-1] && (|div_rsp.quot[QuotW-2:0])) begin
      deriv_d = {1'b1, {(QuotW-1){1'b0}}};
    end else begin
      deriv_d = -div_rsp.quot;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser) begin
            state_d = S_FIN;
          end else if (in_dt == '0) begin
            state_d = S_PD;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV:  if (div_rsp.done) state_d = S_PD;
      S_PD:   state_d = S_DD;
      S_DD:   state_d = S_ID;
      S_ID:   state_d = S_PROV;
      S_PROV: state_d = S_INT;
      S_INT:  state_d = S_I2;
      S_I2:   state_d = S_SUM;
      S_SUM:  state_d = S_FIN;
      S_FIN:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // multiplier operand select and s_axis_tready
  always_comb begin
    s_axis_tready = 1'b0;
    mul_a = gain_p_q;
    mul_b = GainW'(e_q);
    case (state_q)
      S_IDLE: s_axis_tready = 1'b1;
      S_PD: begin
        mul_a = gain_p_q;
        mul_b = GainW'(e_q);
      end
      S_DD: begin
        mul_a = gain_d_q;
        mul_b = deriv_q;
      end
      S_ID, S_I2: begin
        mul_a = gain_i_q;
        mul_b = integ_q;
      end
      S_PROV: begin
        mul_a = GainW'(e_q);
        mul_b = $signed(GainW'(dt_q));
      end
      default: begin
        mul_a = gain_p_q;
        mul_b = GainW'(e_q);
      end
    endcase
  end

  assign prod_d  = mul_a * mul_b;
  assign ishr    = prod_q >>> 16;
  assign lim     = $signed({{(ProdW-OBoundW-16){1'b0}}, obound_q, 16'h0000});
  assign neg_lim = -lim;
  assign worsen  = ((sum_q > lim) && !e_q[ErrW-1] && (e_q != '0)) ||
                   ((sum_q < neg_lim) && e_q[ErrW-1]);

  assign ni     = {{2{integ_q[IntW-1]}}, integ_q} + prod_q[IntW+1:0];
  assign ib_pos = $signed({3'b000, ibound_q});
  assign ib_neg = -ib_pos;

  always_comb begin
    if (ni > ib_pos) begin
      ni_clamp = ib_pos[IntW-1:0];
    end else if (ni < ib_neg) begin
      ni_clamp = ib_neg[IntW-1:0];
    end else begin
      ni_clamp = ni[IntW-1:0];
    end
    if (sum_q > lim) begin
      clamped = lim;
    end else if (sum_q < neg_lim) begin
      clamped = neg_lim;
    end else begin
      clamped = sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      ibound_q    <= '1;
      obound_q    <= '1;
      integ_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GAIN_P: gain_p_q <= cfg_data_i;
          CFG_GAIN_I: gain_i_q <= cfg_data_i;
          CFG_GAIN_D: gain_d_q <= cfg_data_i;
          CFG_IBOUND: ibound_q <= cfg_data_i[IBoundW-1:0];
          CFG_OBOUND: obound_q <= cfg_data_i[OBoundW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        last_q <= s_axis_tuser ? '0 : in_err;
        if (s_axis_tuser) begin
          integ_q <= '0;
        end
      end
      if (state_q == S_INT && !worsen) begin
        integ_q <= ni_clamp;
      end
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (accept) begin
      e_q     <= in_err;
      dt_q    <= in_dt;
      clr_q   <= s_axis_tuser;
      neg_q   <= diff[ErrW];
      deriv_q <= '0;
    end
    if (state_q == S_DIV && div_rsp.done) begin
      deriv_q <= deriv_d;
    end
    case (state_q)
      S_DD:   acc_q <= prod_q;
      S_ID:   acc_q <= acc_q + prod_q;
      S_PROV: sum_q <= acc_q + ishr;
      S_SUM:  sum_q <= acc_q + ishr;
      default: ;
    endcase
    if (state_q == S_FIN && out_free) begin
      out_data_q <= clr_q ? '0 : clamped[ErrW+15:16];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> !s_axis_tready)
    else $error("input taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside its step");
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_axis_tready |-> !div_rsp.busy)
    else $error("ready while divider busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tuser |=> integ_q == '0 && last_q == '0)
    else $error("clear did not zero state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      ($signed(m_axis_tdata) <= $signed({1'b0, obound_q})) &&
      ($signed(m_axis_tdata) >= -$signed({1'b0, obound_q})))
    else $error("drive beyond output bound");

endmodule

`default_nettype wire

### tb/sv/tb_pid_conditional_antiwindup.sv
// Self-checking testbench for the conditional anti-windup PID controller.
`timescale 1ns / 100ps

module tb_pid_conditional_antiwindup;
  import pidc_pkg::*;

  localparam int    CycleLimit = 1000000;
  localparam int    HoldLen    = 400;
  localparam int    CfgChunk   = 60;
  localparam longint SatLo     = -64'sd2147483648;
  localparam longint SatHi     = 64'sd2147483647;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata  = '0;  // error_sample, time_step
  logic                s_axis_tuser  = 1'b0;  // clear_state
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;  // drive
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgW-1:0]     cfg_data_i    = '0;

  // controller state and registers as the testbench sees them
  longint kp = 0;
  longint ki = 0;
  longint kd = 0;
  longint integ_bound = 64'sd2147483647;
  longint drive_bound = 64'sd32767;
  longint integ_acc = 0;
  longint prev_err = 0;

  logic [15:0] drive_q[$];
  int          mismatch_cnt = 0;
  int          src_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_seq = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  pid_conditional_antiwindup uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint pid_combine(longint e, longint acc, longint deriv);
    return kp * e + ((ki * acc) >>> 16) + kd * deriv;
  endfunction

  function automatic logic [15:0] predict_drive(logic signed [15:0] err, logic [15:0] dt,
                                                logic clr);
    longint e, d, deriv, lim, prov, sum;
    bit     pushes_out;
    e = err;
    d = dt;
    deriv = 0;
    if (clr) begin
      integ_acc = 0;
      prev_err = 0;
      return 16'h0000;
    end
    if (d != 0) begin
      deriv = clamp(((e - prev_err) * 65536) / d, SatLo, SatHi);
    end
    prev_err = e;
    lim = drive_bound * 65536;
    prov = pid_combine(e, integ_acc, deriv);
    pushes_out = (prov > lim && e > 0) || (prov < -lim && e < 0);
    if (!pushes_out) begin
      integ_acc = clamp(integ_acc + e * d, -integ_bound, integ_bound);
    end
    sum = clamp(pid_combine(e, integ_acc, deriv), -lim, lim) >>> 16;
    return sum[15:0];
  endfunction

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GAIN_P: kp = longint'($signed(data));
      CFG_GAIN_I: ki = longint'($signed(data));
      CFG_GAIN_D: kd = longint'($signed(data));
      CFG_IBOUND: integ_bound = longint'({1'b0, data[IBoundW-1:0]});
      CFG_OBOUND: drive_bound = longint'({1'b0, data[OBoundW-1:0]});
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic signed [15:0] err, logic [15:0] dt, logic clr);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dt, err};
    s_axis_tuser  <= clr;
    do @(posedge clk_i); while (!s_axis_tready);
    drive_q.push_back(predict_drive(err, dt, clr));
  endtask

  // drop valid and hold until every expected drive has been seen
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($urandom_range(0, 262144)) - 32'd131072;
      2: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return 32'h0000_0000;
      default: return 32'($urandom_range(0, 8192)) - 32'd4096;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_error();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 512)) - 16'd256;
      2: begin
        case ($urandom_range(0, 4))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0001;
          3: return 16'shFFFF;
          default: return 16'sh0000;
        endcase
      end
      default: return 16'($urandom_range(0, 8192)) - 16'd4096;
    endcase
  endfunction

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1, 2: return 16'($urandom_range(1, 16));
      3, 4: return 16'($urandom);
      default: return 16'($urandom_range(1, 1024));
    endcase
  endfunction

  task automatic randomize_config();
    logic [31:0] data;
    cfg_write(CFG_GAIN_P, rand_gain());
    cfg_write(CFG_GAIN_I, rand_gain());
    cfg_write(CFG_GAIN_D, rand_gain());
    data = $urandom;
    case ($urandom_range(0, 3))
      0: data[30:0] = '0;
      1: data[30:0] = '1;
      2: ;
      default: data[30:0] = 31'($urandom_range(0, 32'h0100_0000));
    endcase
    cfg_write(CFG_IBOUND, data);
    data = $urandom;
    case ($urandom_range(0, 3))
      0: data[14:0] = '0;
      1: data[14:0] = '1;
      2: ;
      default: data[14:0] = 15'($urandom_range(1, 512));
    endcase
    cfg_write(CFG_OBOUND, data);
  endtask

  task automatic test_reset_values();
    send_sample(16'sh7FFF, 16'hFFFF, 1'b0);
    send_sample(16'sh8000, 16'h0000, 1'b0);
    send_sample(16'sh0100, 16'h0040, 1'b1);
    drain();
  endtask

  task automatic test_field_extremes();
    cfg_write(CFG_GAIN_P, 32'h0001_0000);
    cfg_write(CFG_GAIN_I, 32'h0001_0000);
    cfg_write(CFG_GAIN_D, 32'h0000_0100);
    send_sample(16'sh7FFF, 16'hFFFF, 1'b0);
    send_sample(16'sh8000, 16'hFFFF, 1'b0);
    send_sample(16'sh0000, 16'h0000, 1'b0);
    send_sample(16'sh8000, 16'h0001, 1'b0);
    send_sample(16'sh7FFF, 16'hFFFF, 1'b1);
    drain();
  endtask

  task automatic test_derivative_limits();
    cfg_write(CFG_GAIN_P, 32'h0000_0000);
    cfg_write(CFG_GAIN_I, 32'h0000_0000);
    cfg_write(CFG_GAIN_D, 32'h0000_0001);
    send_sample(16'sh7FFF, 16'h0001, 1'b0);
    send_sample(16'sh8000, 16'h0001, 1'b0);
    send_sample(16'sh7FFF, 16'h0001, 1'b0);
    send_sample(16'sh1234, 16'h0000, 1'b0);
    drain();
    cfg_write(CFG_GAIN_D, 32'h8000_0000);
    send_sample(16'sh8000, 16'h0001, 1'b0);
    send_sample(16'sh7FFF, 16'h0003, 1'b0);
    drain();
  endtask

  task automatic test_windup_hold();
    cfg_write(CFG_GAIN_P, 32'h7FFF_FFFF);
    cfg_write(CFG_GAIN_I, 32'h0001_0000);
    cfg_write(CFG_GAIN_D, 32'h0000_0000);
    cfg_write(CFG_OBOUND, 32'h0000_0064);
    send_sample(16'sh0064, 16'h03E8, 1'b0);
    send_sample(-16'sh0064, 16'h03E8, 1'b0);
    send_sample(16'sh0000, 16'h03E8, 1'b0);
    drain();
  endtask

  task automatic test_lowered_bound();
    cfg_write(CFG_GAIN_P, 32'h0000_0000);
    cfg_write(CFG_OBOUND, 32'h0000_7FFF);
    cfg_write(CFG_IBOUND, 32'h7FFF_FFFF);
    send_sample(16'sh7FFF, 16'hFFFF, 1'b0);
    send_sample(16'sh7FFF, 16'hFFFF, 1'b0);
    drain();
    cfg_write(CFG_IBOUND, 32'h0000_03E8);
    cfg_write(CFG_GAIN_P, 32'h7FFF_FFFF);
    cfg_write(CFG_OBOUND, 32'h0000_0064);
    send_sample(16'sh0032, 16'h000A, 1'b0);
    drain();
    cfg_write(CFG_GAIN_P, 32'h0000_0000);
    send_sample(-16'sh0001, 16'h0001, 1'b0);
    drain();
    cfg_write(CFG_IBOUND, 32'h0000_0000);
    cfg_write(CFG_OBOUND, 32'h0000_0000);
    send_sample(16'sh0200, 16'h0100, 1'b0);
    drain();
  endtask

  task automatic test_spare_index();
    for (int k = 1; k <= 3; k++) cfg_write(CFG_OBOUND + CfgIdxW'(k), $urandom);
    send_sample(16'sh0400, 16'h0010, 1'b0);
    drain();
  endtask

  task automatic test_random_phase(int idle_pct, int stall, int count);
    src_idle_pct = idle_pct;
    stall_pct    = stall;
    for (int n = 0; n < count; n++) begin
      if (n % CfgChunk == 0) begin
        drain();
        randomize_config();
      end
      send_sample(rand_error(), rand_dt(), ($urandom_range(0, 99) < 3));
    end
    drain();
  endtask

  task automatic test_output_backpressure();
    src_idle_pct = 0;
    stall_pct    = 0;
    cfg_write(CFG_GAIN_P, 32'h0000_8000);
    cfg_write(CFG_GAIN_I, 32'h0000_4000);
    cfg_write(CFG_GAIN_D, 32'h0000_0010);
    cfg_write(CFG_IBOUND, 32'h7FFF_FFFF);
    cfg_write(CFG_OBOUND, 32'h0000_7FFF);
    hold_seq = hold_seq + 1;
    for (int n = 0; n < 12; n++) send_sample(rand_error(), rand_dt(), 1'b0);
    drain();
  endtask

  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_drive
    logic [15:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected drive transfer: expected none, actual %0d", $time,
                 $signed(m_axis_tdata));
        mismatch_cnt = mismatch_cnt + 1;
      end else begin
        want = drive_q.pop_front();
        if (m_axis_tdata !== want) begin
          $display("%0t: drive mismatch: expected %0d, actual %0d", $time, $signed(want),
                   $signed(m_axis_tdata));
          mismatch_cnt = mismatch_cnt + 1;
        end
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb_pid_conditional_antiwindup: FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_field_extremes();
    test_derivative_limits();
    test_windup_hold();
    test_lowered_bound();
    test_spare_index();
    test_random_phase(0, 0, 500);
    test_random_phase(64, 0, 480);
    test_random_phase(0, 64, 480);
    test_random_phase(31, 31, 480);
    test_output_backpressure();
    drain();
    repeat (60) @(posedge clk_i);
    if (drive_q.size() != 0) begin
      $display("%0t: %0d drive transfers missing", $time, drive_q.size());
    end
    if (mismatch_cnt == 0 && drive_q.size() == 0) begin
      $display("tb_pid_conditional_antiwindup: PASS");
    end else begin
      $display("tb_pid_conditional_antiwindup: FAIL");
    end
    $finish;
  end

endmodule

### files.f
design/pidc_pkg.sv
design/pidc_div.sv
design/pid_conditional_antiwindup.sv
tb/sv/tb_pid_conditional_antiwindup.sv
